/* src/pidctl_pkg.sv */
// pidctl_pkg: widths, register codes, mode codes and clamp helper for the
// two-form pid controller. No dependencies.
`default_nettype none

package pidctl_pkg;

	localparam int GAIN_FRAC_BITS = 16;

	localparam int IN_W      = 16;
	localparam int ERR_W     = IN_W + 1;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int DIFF2_W   = ERR_W + 2;
	localparam int DATA_W    = 32;
	localparam int LIMIT_W   = 31;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int TERM_W    = PROD_W - GAIN_FRAC_BITS;
	localparam int SUM_W     = TERM_W + 2;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE           = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_OUTPUT_LIMIT   = 3'd5,
		REG_STEP_LIMIT     = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		MODE_POSITIONAL  = 1'b0,
		MODE_INCREMENTAL = 1'b1
	} ctl_mode_t;

	// symmetric clamp of a wide signed value to +/-lim
	function automatic logic signed [DATA_W-1:0] clamp_sym(
		input logic signed [SUM_W-1:0] v,
		input logic [LIMIT_W-1:0] lim
	);
		logic signed [SUM_W-1:0]  lim_w;
		logic signed [DATA_W-1:0] lim_d;
		lim_w = $signed({{(SUM_W - LIMIT_W){1'b0}}, lim});
		lim_d = $signed({{(DATA_W - LIMIT_W){1'b0}}, lim});
		if (v > lim_w) begin
			return lim_d;
		end else if (v < -lim_w) begin
			return -lim_d;
		end else begin
			return v[DATA_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

/* src/pid_controller_two_forms.sv */
// pid_controller_two_forms: four-stage pid pipeline with positional and
// incremental forms, configuration registers and error history.
// Depends on pidctl_pkg.
//
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    setpoint, measured
// out       source     out_valid / out_stall  drive, change
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each passes stages 1 to 4 in turn.
// Stage 1 forms the error and closes the error-history loop, stage 2 holds
// the three gain products, stage 3 sums and clamps, stage 4 closes the
// running-drive loop and is the output register.
// Reset clears configuration, controller state and stage valid bits.
// A stalled output backs the stages up; input is taken while any stage is free.
`default_nettype none

module pid_controller_two_forms (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [pidctl_pkg::IN_W-1:0]     setpoint,
	input  wire logic signed [pidctl_pkg::IN_W-1:0]     measured,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [pidctl_pkg::DATA_W-1:0]        drive,
	output logic signed [pidctl_pkg::DATA_W-1:0]        change,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [pidctl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pidctl_pkg::DATA_W-1:0]          cfg_data
);

	localparam int ERR_W   = pidctl_pkg::ERR_W;
	localparam int DIFF2_W = pidctl_pkg::DIFF2_W;
	localparam int DATA_W  = pidctl_pkg::DATA_W;
	localparam int LIMIT_W = pidctl_pkg::LIMIT_W;
	localparam int PROD_W  = pidctl_pkg::PROD_W;
	localparam int TERM_W  = pidctl_pkg::TERM_W;
	localparam int SUM_W   = pidctl_pkg::SUM_W;
	localparam int FRAC    = pidctl_pkg::GAIN_FRAC_BITS;

	// configuration
	pidctl_pkg::ctl_mode_t      mode_q;
	logic signed [DATA_W-1:0]   gain_p_q;
	logic signed [DATA_W-1:0]   gain_i_q;
	logic signed [DATA_W-1:0]   gain_d_q;
	logic [LIMIT_W-1:0]         integral_limit_q;
	logic [LIMIT_W-1:0]         output_limit_q;
	logic [LIMIT_W-1:0]         step_limit_q;

	// controller state
	logic signed [DATA_W-1:0]   error_sum_q;
	logic signed [ERR_W-1:0]    prior_error_q;
	logic signed [ERR_W-1:0]    older_error_q;
	logic signed [DATA_W-1:0]   running_drive_q;

	// pipeline
	logic                       valid_s1, valid_s2, valid_s3, valid_s4;
	logic                       ready_s1, ready_s2, ready_s3, ready_s4;
	logic                       accept;
	pidctl_pkg::ctl_mode_t      mode_s1, mode_s2, mode_s3, mode_s4;
	logic signed [DATA_W-1:0]   op_p_s1, op_i_s1, op_d_s1;
	logic signed [TERM_W-1:0]   term_p_s2, term_i_s2, term_d_s2;
	logic signed [DATA_W-1:0]   clamped_s3;
	logic signed [DATA_W-1:0]   drive_s4, change_s4;

	// stage 1 logic
	logic signed [ERR_W-1:0]    err;
	logic signed [DIFF2_W-1:0]  err_x, prior_x, older_x;
	logic signed [DIFF2_W-1:0]  diff1, diff2;
	logic signed [SUM_W-1:0]    esum_wide;
	logic signed [DATA_W-1:0]   esum_next;
	logic signed [DATA_W-1:0]   op_p, op_i, op_d;

	// stage 2 logic
	logic signed [PROD_W-1:0]   prod_p, prod_i, prod_d;

	// stage 3 logic
	logic signed [SUM_W-1:0]    term_sum;
	logic signed [DATA_W-1:0]   clamped;

	// stage 4 logic
	logic signed [DATA_W:0]     acc_next;
	logic signed [DATA_W-1:0]   acc_sat;

	assign ready_s4  = !valid_s4 || !out_stall;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign accept    = in_valid && ready_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= pidctl_pkg::MODE_POSITIONAL;
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= '0;
			output_limit_q   <= '0;
			step_limit_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pidctl_pkg::cfg_reg_t'(cfg_index))
				pidctl_pkg::REG_MODE:           mode_q <= pidctl_pkg::ctl_mode_t'(cfg_data[0]);
				pidctl_pkg::REG_GAIN_P:         gain_p_q <= $signed(cfg_data);
				pidctl_pkg::REG_GAIN_I:         gain_i_q <= $signed(cfg_data);
				pidctl_pkg::REG_GAIN_D:         gain_d_q <= $signed(cfg_data);
				pidctl_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIMIT_W-1:0];
				pidctl_pkg::REG_OUTPUT_LIMIT:   output_limit_q <= cfg_data[LIMIT_W-1:0];
				pidctl_pkg::REG_STEP_LIMIT:     step_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: error, history and multiplier operands
	always_comb begin
		err     = $signed({setpoint[pidctl_pkg::IN_W-1], setpoint})
		        - $signed({measured[pidctl_pkg::IN_W-1], measured});
		err_x   = $signed({{(DIFF2_W - ERR_W){err[ERR_W-1]}}, err});
		prior_x = $signed({{(DIFF2_W - ERR_W){prior_error_q[ERR_W-1]}}, prior_error_q});
		older_x = $signed({{(DIFF2_W - ERR_W){older_error_q[ERR_W-1]}}, older_error_q});
		diff1   = err_x - prior_x;
		diff2   = err_x - (prior_x <<< 1) + older_x;

		esum_wide = $signed({{(SUM_W - DATA_W){error_sum_q[DATA_W-1]}}, error_sum_q})
		          + $signed({{(SUM_W - ERR_W){err[ERR_W-1]}}, err});
		if (gain_i_q != '0) begin
			esum_next = pidctl_pkg::clamp_sym(esum_wide, integral_limit_q);
		end else begin
			esum_next = error_sum_q;
		end

		if (mode_q == pidctl_pkg::MODE_POSITIONAL) begin
			op_p = $signed({{(DATA_W - ERR_W){err[ERR_W-1]}}, err});
			op_i = esum_next;
			op_d = $signed({{(DATA_W - DIFF2_W){diff1[DIFF2_W-1]}}, diff1});
		end else begin
			op_p = $signed({{(DATA_W - DIFF2_W){diff1[DIFF2_W-1]}}, diff1});
			op_i = $signed({{(DATA_W - ERR_W){err[ERR_W-1]}}, err});
			op_d = $signed({{(DATA_W - DIFF2_W){diff2[DIFF2_W-1]}}, diff2});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q   <= '0;
			prior_error_q <= '0;
			older_error_q <= '0;
		end else if (accept) begin
			prior_error_q <= err;
			if (mode_q == pidctl_pkg::MODE_POSITIONAL) begin
				error_sum_q <= esum_next;
			end else begin
				older_error_q <= prior_error_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_q;
			op_p_s1 <= op_p;
			op_i_s1 <= op_i;
			op_d_s1 <= op_d;
		end
	end

	// stage 2: gain products, floor shift by the fraction bits
	assign prod_p = $signed({{(PROD_W - DATA_W){gain_p_q[DATA_W-1]}}, gain_p_q})
	              * $signed({{(PROD_W - DATA_W){op_p_s1[DATA_W-1]}}, op_p_s1});
	assign prod_i = $signed({{(PROD_W - DATA_W){gain_i_q[DATA_W-1]}}, gain_i_q})
	              * $signed({{(PROD_W - DATA_W){op_i_s1[DATA_W-1]}}, op_i_s1});
	assign prod_d = $signed({{(PROD_W - DATA_W){gain_d_q[DATA_W-1]}}, gain_d_q})
	              * $signed({{(PROD_W - DATA_W){op_d_s1[DATA_W-1]}}, op_d_s1});

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			mode_s2   <= mode_s1;
			term_p_s2 <= prod_p[PROD_W-1:FRAC];
			term_i_s2 <= prod_i[PROD_W-1:FRAC];
			term_d_s2 <= prod_d[PROD_W-1:FRAC];
		end
	end

	// stage 3: term sum and clamp
	always_comb begin
		term_sum = $signed({{(SUM_W - TERM_W){term_p_s2[TERM_W-1]}}, term_p_s2})
		         + $signed({{(SUM_W - TERM_W){term_i_s2[TERM_W-1]}}, term_i_s2})
		         + $signed({{(SUM_W - TERM_W){term_d_s2[TERM_W-1]}}, term_d_s2});
		if (mode_s2 == pidctl_pkg::MODE_POSITIONAL) begin
			clamped = pidctl_pkg::clamp_sym(term_sum, output_limit_q);
		end else begin
			clamped = pidctl_pkg::clamp_sym(term_sum, step_limit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			mode_s3    <= mode_s2;
			clamped_s3 <= clamped;
		end
	end

	// stage 4: running drive, with 32-bit saturation in incremental mode
	always_comb begin
		acc_next = $signed({running_drive_q[DATA_W-1], running_drive_q})
		         + $signed({clamped_s3[DATA_W-1], clamped_s3});
		if (acc_next[DATA_W] != acc_next[DATA_W-1]) begin
			acc_sat = acc_next[DATA_W] ? $signed({1'b1, {(DATA_W - 1){1'b0}}})
			                           : $signed({1'b0, {(DATA_W - 1){1'b1}}});
		end else begin
			acc_sat = acc_next[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_drive_q <= '0;
		end else if (valid_s3 && ready_s4) begin
			if (mode_s3 == pidctl_pkg::MODE_POSITIONAL) begin
				running_drive_q <= clamped_s3;
			end else begin
				running_drive_q <= acc_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			mode_s4 <= mode_s3;
			if (mode_s3 == pidctl_pkg::MODE_POSITIONAL) begin
				drive_s4  <= clamped_s3;
				change_s4 <= '0;
			end else begin
				drive_s4  <= acc_sat;
				change_s4 <= clamped_s3;
			end
		end
	end

	assign out_valid = valid_s4;
	assign drive     = drive_s4;
	assign change    = (mode_s4 == pidctl_pkg::MODE_POSITIONAL) ? '0 : change_s4;

endmodule

`default_nettype wire
